FILE: rtl/source_code_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer checker
`ifndef SOURCE_CODE_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_CODE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define STC_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, quiet during reset
`define STC_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// Next-cycle implication that also holds across reset
`define STC_ASSERT_RST(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/stc_pkg.sv
// Package: token kinds, character codes, result bundle type and classification helpers
`timescale 1ns / 1ps
`default_nettype none
package stc_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int QDEPTH = 2;
  localparam int QPTR_BITS = 1;

  // token kinds
  localparam logic [5:0] KIND_TERM   = 6'd0;
  localparam logic [5:0] KIND_EQ     = 6'd1;
  localparam logic [5:0] KIND_NE     = 6'd2;
  localparam logic [5:0] KIND_GE     = 6'd3;
  localparam logic [5:0] KIND_LE     = 6'd4;
  localparam logic [5:0] KIND_SHL    = 6'd5;
  localparam logic [5:0] KIND_SHR    = 6'd6;
  localparam logic [5:0] KIND_LAND   = 6'd7;
  localparam logic [5:0] KIND_LOR    = 6'd8;
  localparam logic [5:0] KIND_SINGLE = 6'd9;
  localparam logic [5:0] KIND_CHAR   = 6'd29;
  localparam logic [5:0] KIND_STR    = 6'd30;
  localparam logic [5:0] KIND_INT    = 6'd31;
  localparam logic [5:0] KIND_FLOAT  = 6'd32;
  localparam logic [5:0] KIND_KW     = 6'd33;
  localparam logic [5:0] KIND_IDENT  = 6'd45;

  // character codes
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // one result record
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
  } slot_t;

  // results of one byte: held op, flushed token, end-of-text token, terminator
  typedef struct packed {
    logic [3:0]      v;
    slot_t [2:0]     s;
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } opinfo_t;

  function automatic opinfo_t op_index(input logic [7:0] c);
    opinfo_t r;
    r.hit = 1'b1;
    r.idx = 5'd0;
    case (c)
      CH_SEMI:  r.idx = 5'd0;
      CH_COMMA: r.idx = 5'd1;
      CH_LBRC:  r.idx = 5'd2;
      CH_RBRC:  r.idx = 5'd3;
      CH_LBRK:  r.idx = 5'd4;
      CH_RBRK:  r.idx = 5'd5;
      CH_LPAR:  r.idx = 5'd6;
      CH_RPAR:  r.idx = 5'd7;
      CH_EQ:    r.idx = 5'd8;
      CH_PLUS:  r.idx = 5'd9;
      CH_MINUS: r.idx = 5'd10;
      CH_STAR:  r.idx = 5'd11;
      CH_SLASH: r.idx = 5'd12;
      CH_AMP:   r.idx = 5'd13;
      CH_PIPE:  r.idx = 5'd14;
      CH_CARET: r.idx = 5'd15;
      CH_TILDE: r.idx = 5'd16;
      CH_GT:    r.idx = 5'd17;
      CH_LT:    r.idx = 5'd18;
      CH_BANG:  r.idx = 5'd19;
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] single_kind(input logic [4:0] idx);
    return KIND_SINGLE + {1'b0, idx};
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = KIND_TERM;
    if (a == CH_EQ   && b == CH_EQ)   k = KIND_EQ;
    if (a == CH_BANG && b == CH_EQ)   k = KIND_NE;
    if (a == CH_GT   && b == CH_EQ)   k = KIND_GE;
    if (a == CH_LT   && b == CH_EQ)   k = KIND_LE;
    if (a == CH_LT   && b == CH_LT)   k = KIND_SHL;
    if (a == CH_GT   && b == CH_GT)   k = KIND_SHR;
    if (a == CH_AMP  && b == CH_AMP)  k = KIND_LAND;
    if (a == CH_PIPE && b == CH_PIPE) k = KIND_LOR;
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  // keyword text, first character in the low byte, zero padded
  function automatic logic [47:0] kw_word(input logic [3:0] k);
    logic [47:0] w;
    case (k)
      4'd0:    w = {16'h0000, "etyb"};
      4'd1:    w = {8'h00, "trohs"};
      4'd2:    w = {24'h000000, "tni"};
      4'd3:    w = {16'h0000, "gnol"};
      4'd4:    w = {16'h0000, "rahc"};
      4'd5:    w = {8'h00, "taolf"};
      4'd6:    w = "elbuod";
      4'd7:    w = "gnirts";
      4'd8:    w = {32'h00000000, "fi"};
      4'd9:    w = {16'h0000, "esle"};
      4'd10:   w = {8'h00, "elihw"};
      4'd11:   w = "nruter";
      default: w = 48'h0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] n;
    case (k)
      4'd0, 4'd3, 4'd4, 4'd9:   n = 3'd4;
      4'd1, 4'd5, 4'd10:        n = 3'd5;
      4'd2:                     n = 3'd3;
      4'd6, 4'd7, 4'd11:        n = 3'd6;
      4'd8:                     n = 3'd2;
      default:                  n = 3'd0;
    endcase
    return n;
  endfunction

  // classify a finished token; len_c is the length clipped to seven
  function automatic logic [5:0] classify(input logic [2:0] len_c, input logic [47:0] pfx,
                                          input logic [7:0] prev, input logic nok,
                                          input logic pt, input logic iok);
    logic [7:0] c0;
    logic [5:0] pk;
    logic [5:0] kw;
    logic       kw_hit;
    opinfo_t    oi;
    logic [5:0] k;
    c0 = pfx[7:0];
    pk = pair_kind(c0, pfx[15:8]);
    oi = op_index(c0);
    kw_hit = 1'b0;
    kw = KIND_KW;
    for (int i = 11; i >= 0; i--) begin
      if (len_c == kw_len(4'(i)) && pfx == kw_word(4'(i))) begin
        kw_hit = 1'b1;
        kw = KIND_KW + 6'(i);
      end
    end
    if (len_c == 3'd2 && pk != KIND_TERM)                 k = pk;
    else if (len_c == 3'd1 && oi.hit)                     k = single_kind(oi.idx);
    else if (c0 == CH_SQUOT && len_c == 3'd3)             k = KIND_CHAR;
    else if (c0 == CH_DQUOT && len_c >= 3'd3 && prev == CH_DQUOT) k = KIND_STR;
    else if (is_digit(c0))  k = nok ? (pt ? KIND_FLOAT : KIND_INT) : KIND_TERM;
    else if (is_alpha(c0)) begin
      if (kw_hit)                 k = kw;
      else if (len_c == 3'd1)     k = KIND_IDENT;
      else                        k = iok ? KIND_IDENT : KIND_TERM;
    end
    else                          k = KIND_TERM;
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/stc_front.sv
// Front end: accepts bytes, tracks token state and builds the result bundle of each byte
`timescale 1ns / 1ps
`default_nettype none
module stc_front #(
  parameter int PB = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_source_char,
  input  wire logic             in_end_of_text,
  input  wire logic             q_full,
  output logic                  push,
  output stc_pkg::bundle_t      bundle
);
  import stc_pkg::*;

  localparam logic [PB-1:0] ONE = {{(PB-1){1'b0}}, 1'b1};
  localparam logic [PB-1:0] MAXV = {PB{1'b1}};

  logic [PB-1:0] pos_r, pos_nxt, tbeg_r, tbeg_nxt, row_r, row_nxt, rowb_r, rowb_nxt;
  logic [PB-1:0] plen_r, plen_nxt;
  logic          inq_r, inq_nxt, held_v_r, held_v_nxt;
  logic [7:0]    held_r, held_nxt, prev_r, prev_nxt;
  logic [47:0]   pfx_r, pfx_nxt;
  logic          nok_r, nok_nxt, pt_r, pt_nxt, iok_r, iok_nxt;
  logic          acc;
  bundle_t       bun;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] x);
    return (x == MAXV) ? x : x + ONE;
  endfunction

  function automatic logic [2:0] clip_len(input logic [PB-1:0] x);
    return (x >= PB'(7)) ? 3'd7 : x[2:0];
  endfunction

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign push     = acc && (bun.v != 4'b0000);
  assign bundle   = bun;

  // per-byte token step
  always_comb begin
    logic [7:0]  c;
    logic [5:0]  pk, cls;
    logic        skip, blank, sep;
    opinfo_t     oi, hi;
    c = in_source_char;
    pos_nxt = pos_r; tbeg_nxt = tbeg_r; row_nxt = row_r; rowb_nxt = rowb_r;
    plen_nxt = plen_r; inq_nxt = inq_r; held_v_nxt = held_v_r; held_nxt = held_r;
    prev_nxt = prev_r; pfx_nxt = pfx_r; nok_nxt = nok_r; pt_nxt = pt_r; iok_nxt = iok_r;
    bun = '0;
    skip = 1'b0;
    pk = pair_kind(held_r, c);
    oi = op_index(c);
    hi = op_index(held_r);
    // resolve the held operator against this byte
    if (held_v_r) begin
      bun.v[0]       = 1'b1;
      bun.s[0].start = 16'(tbeg_r);
      bun.s[0].line  = 16'(row_r);
      bun.s[0].col   = 16'(tbeg_r - rowb_r + ONE);
      if (pk != KIND_TERM) begin
        bun.s[0].kind = pk;
        bun.s[0].len  = 16'd2;
        skip = 1'b1;
      end else begin
        bun.s[0].kind = single_kind(hi.idx);
        bun.s[0].len  = 16'd1;
      end
      held_v_nxt = 1'b0;
    end
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    sep   = (blank || oi.hit) && !inq_r;
    cls   = classify(clip_len(plen_r), pfx_r, prev_r, nok_r, pt_r, iok_r);
    if (!skip) begin
      if (sep) begin
        // flush pending token, then advance row and hold an operator
        if (plen_r != '0 && cls != KIND_TERM) begin
          bun.v[1]       = 1'b1;
          bun.s[1].kind  = cls;
          bun.s[1].start = 16'(tbeg_r);
          bun.s[1].len   = 16'(plen_r);
          bun.s[1].line  = 16'(row_r);
          bun.s[1].col   = 16'(tbeg_r - rowb_r + ONE);
        end
        plen_nxt = '0;
        if (c == CH_NL) begin
          row_nxt  = sat_inc(row_r);
          rowb_nxt = sat_inc(pos_r);
        end
        if (oi.hit) begin
          held_nxt   = c;
          held_v_nxt = 1'b1;
          tbeg_nxt   = pos_r;
        end
      end else begin
        // append to pending token
        if (c == CH_DQUOT) inq_nxt = !inq_r;
        if (plen_r == '0) begin
          tbeg_nxt = pos_r;
          pfx_nxt  = '0;
          nok_nxt  = 1'b1;
          pt_nxt   = 1'b0;
          iok_nxt  = 1'b1;
        end else begin
          if (!is_digit(c)) begin
            if (c == CH_POINT && !pt_r) pt_nxt = 1'b1;
            else                        nok_nxt = 1'b0;
          end
          if (!is_digit(c) && !is_alpha(c)) iok_nxt = 1'b0;
        end
        for (int i = 0; i < 6; i++) begin
          if (plen_r == PB'(i)) pfx_nxt[8*i +: 8] = c;
        end
        prev_nxt = c;
        plen_nxt = sat_inc(plen_r);
      end
    end
    pos_nxt = sat_inc(pos_r);
    // end of text: drain held op or pending token, add terminator, restart
    if (in_end_of_text) begin
      bun.s[2].start = 16'(tbeg_nxt);
      bun.s[2].line  = 16'(row_nxt);
      bun.s[2].col   = 16'(tbeg_nxt - rowb_nxt + ONE);
      if (held_v_nxt) begin
        bun.v[2]      = 1'b1;
        bun.s[2].kind = single_kind(oi.idx);
        bun.s[2].len  = 16'd1;
      end else begin
        bun.s[2].kind = classify(clip_len(plen_nxt), pfx_nxt, prev_nxt, nok_nxt, pt_nxt,
                                 iok_nxt);
        bun.s[2].len  = 16'(plen_nxt);
        bun.v[2]      = (plen_nxt != '0) && (bun.s[2].kind != KIND_TERM);
      end
      bun.v[3] = 1'b1;
      pos_nxt = '0; tbeg_nxt = '0; row_nxt = ONE; rowb_nxt = '0; plen_nxt = '0;
      inq_nxt = 1'b0; held_v_nxt = 1'b0; held_nxt = 8'h00; prev_nxt = 8'h00;
      pfx_nxt = '0; nok_nxt = 1'b1; pt_nxt = 1'b0; iok_nxt = 1'b1;
    end
  end

  // token state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; tbeg_r <= '0; row_r <= ONE; rowb_r <= '0; plen_r <= '0;
      inq_r <= 1'b0; held_v_r <= 1'b0; held_r <= 8'h00; prev_r <= 8'h00;
      pfx_r <= '0; nok_r <= 1'b1; pt_r <= 1'b0; iok_r <= 1'b1;
    end else if (acc) begin
      pos_r <= pos_nxt; tbeg_r <= tbeg_nxt; row_r <= row_nxt; rowb_r <= rowb_nxt;
      plen_r <= plen_nxt; inq_r <= inq_nxt; held_v_r <= held_v_nxt; held_r <= held_nxt;
      prev_r <= prev_nxt; pfx_r <= pfx_nxt; nok_r <= nok_nxt; pt_r <= pt_nxt;
      iok_r <= iok_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stc_queue.sv
// Two-entry bundle queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module stc_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire stc_pkg::bundle_t wr_data,
  input  wire logic             pop,
  output stc_pkg::bundle_t      rd_data,
  output logic                  not_empty,
  output logic                  full
);
  import stc_pkg::*;

  bundle_t              mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;

  assign rd_data   = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (QPTR_BITS+1)'(QDEPTH));

  // occupancy follows push and pop
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

FILE: rtl/stc_back.sv
// Back end: sends the results of the head bundle one beat at a time
`timescale 1ns / 1ps
`default_nettype none
module stc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire stc_pkg::bundle_t head,
  input  wire logic             head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [5:0]            out_token_kind,
  output logic [15:0]           out_token_start,
  output logic [15:0]           out_token_length,
  output logic [15:0]           out_line_number,
  output logic [15:0]           out_column_number,
  output logic                  out_last_result
);
  import stc_pkg::*;

  logic [3:0] done_r, done_nxt, rem, sel;
  logic       acc;
  slot_t      s;

  assign rem       = head.v & ~done_r;
  assign sel       = rem & (~rem + 4'd1);
  assign out_valid = head_valid && (rem != 4'b0000);
  assign acc       = out_valid && !out_stall;
  assign pop       = acc && (rem == sel);

  // pick the earliest result not yet sent
  always_comb begin
    s = '0;
    if (sel[0])      s = head.s[0];
    else if (sel[1]) s = head.s[1];
    else if (sel[2]) s = head.s[2];
    done_nxt = done_r;
    if (acc) done_nxt = pop ? 4'b0000 : (done_r | sel);
  end

  assign out_token_kind    = s.kind;
  assign out_token_start   = s.start;
  assign out_token_length  = s.len;
  assign out_line_number   = s.line;
  assign out_column_number = s.col;
  assign out_last_result   = sel[3];

  // mark sent beats of the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 4'b0000;
    else        done_r <= done_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/source_code_tokenizer_top.sv
// Tokenizer top level: splits a byte stream into classified tokens
//
// Input channel: one source byte per beat with an end-of-text flag on the last byte.
// Output channel: one token per beat (kind, start offset, length, row, column); after
// the final byte a terminator beat with last_result set and all other fields zero.
// Unknown tokens are dropped and never appear on the output.
// Throughput: one byte per cycle while each byte yields at most one token and the
// receiver does not stall; a byte that closes several tokens sends one per beat on the
// single output port. A token enters the queue when its completing byte is taken;
// operator characters are held one byte for pairing, so they complete on the next byte.
// A two-entry bundle queue separates the byte stage from the output stage.
// Reset clears all token state and the queue; row starts at 1, offset at 0. After the
// terminator the block restarts as if from reset.
// When the receiver stalls, the current token holds on the output and the front keeps
// taking bytes until the queue fills, then stalls the sender.
`timescale 1ns / 1ps
`default_nettype none
module source_code_tokenizer_top #(
  parameter int POSITION_BITS = stc_pkg::POSITION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_source_char,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic [15:0]      out_line_number,
  output logic [15:0]      out_column_number,
  output logic             out_last_result
);
  import stc_pkg::*;

  bundle_t wr_b, head;
  logic    push, pop, ne, full;

  stc_front #(.PB(POSITION_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_source_char, .in_end_of_text,
    .q_full(full), .push, .bundle(wr_b)
  );

  stc_queue u_queue (
    .clk, .rst_n, .push, .wr_data(wr_b), .pop, .rd_data(head), .not_empty(ne), .full
  );

  stc_back u_back (
    .clk, .rst_n, .head, .head_valid(ne), .pop, .out_valid, .out_stall,
    .out_token_kind, .out_token_start, .out_token_length, .out_line_number,
    .out_column_number, .out_last_result
  );

endmodule
`default_nettype wire

FILE: rtl/stc_checker.sv
// Port-level checker for the tokenizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "source_code_tokenizer_top_defines.svh"
module stc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_source_char,
  input wire logic        in_end_of_text,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [5:0]  out_token_kind,
  input wire logic [15:0] out_token_start,
  input wire logic [15:0] out_token_length,
  input wire logic [15:0] out_line_number,
  input wire logic [15:0] out_column_number,
  input wire logic        out_last_result
);
  import stc_pkg::*;

  // nothing is shown straight after reset
  `STC_ASSERT_RST(a_rst_quiet, !rst_n, !out_valid, "output valid right after reset")
  // a stalled beat holds
  `STC_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_token_kind) && $stable(out_token_start) && $stable(out_last_result), "stalled beat changed")
  // terminator has zero line and length, and only it has kind zero
  `STC_ASSERT_IMP(a_term, out_valid, (out_last_result == (out_token_kind == KIND_TERM)) && (!out_last_result || (out_line_number == 16'd0 && out_token_length == 16'd0)), "bad terminator beat")

endmodule

bind source_code_tokenizer_top stc_checker u_chk (.*);
`default_nettype wire

FILE: tb/source_code_tokenizer_top_tb.sv
// Self-checking testbench for the source code tokenizer: directed texts, random texts, checks
`timescale 1ns / 1ps
`default_nettype none
module source_code_tokenizer_top_tb;
  import stc_pkg::*;

  localparam longint PMAX = 65535;
  localparam int LIMIT = 1_000_000;
  localparam string OPS = ";,{}[]()=+-*/&|^~><!";
  localparam string PAIR_A = "=!><<>&|";
  localparam string PAIR_B = "====<>&|";

  typedef struct {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  typedef struct {
    string text;
    int    first_kind;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_source_char = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [15:0] out_line_number;
  logic [15:0] out_column_number;
  logic        out_last_result;

  token_t      token_q[$];
  logic [5:0]  kind_log[$];
  byte unsigned text_buf[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          hold_cycles = 0;
  int          idle_pct = 68;
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;

  // tokenizer state mirror
  longint      pos, tok_begin, row_no, row_start, pend_len;
  bit          quoted, held_ok, merged, num_ok, point_ok, ident_ok;
  byte unsigned held, last_ch;
  byte unsigned pfx[6];

  source_code_tokenizer_top DUT (.*);

  always #10 clk = ~clk;

  // hold off the receiver for a counted stretch, otherwise stall at random in receiver idling phases
  always @(negedge clk) begin
    cycle_count++;
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = recv_idle && ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint sat_inc(longint v);
    return v >= PMAX ? PMAX : v + 1;
  endfunction

  function automatic int op_slot(byte unsigned c);
    for (int i = 0; i < 20; i++)
      if (OPS[i] == c) return i;
    return -1;
  endfunction

  function automatic logic [5:0] pair_of(byte unsigned a, byte unsigned b);
    for (int i = 0; i < 8; i++)
      if (PAIR_A[i] == a && PAIR_B[i] == b) return KIND_EQ + 6'(i);
    return KIND_TERM;
  endfunction

  function automatic bit digit(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(byte unsigned c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [5:0] token_class();
    string words[12] = '{"byte", "short", "int", "long", "char", "float", "double",
                         "string", "if", "else", "while", "return"};
    bit    same;
    int    slot;
    if (pend_len == 2 && pair_of(pfx[0], pfx[1]) != KIND_TERM) return pair_of(pfx[0], pfx[1]);
    slot = op_slot(pfx[0]);
    if (pend_len == 1 && slot >= 0) return KIND_SINGLE + 6'(slot);
    if (pfx[0] == CH_SQUOT && pend_len == 3) return KIND_CHAR;
    if (pfx[0] == CH_DQUOT && pend_len >= 3 && last_ch == CH_DQUOT) return KIND_STR;
    if (digit(pfx[0])) return num_ok ? (point_ok ? KIND_FLOAT : KIND_INT) : KIND_TERM;
    if (letter(pfx[0])) begin
      for (int k = 0; k < 12; k++) begin
        if (pend_len != words[k].len()) continue;
        same = 1'b1;
        for (int i = 0; i < words[k].len(); i++)
          if (pfx[i] != words[k][i]) same = 1'b0;
        if (same) return KIND_KW + 6'(k);
      end
      if (pend_len == 1) return KIND_IDENT;
      return ident_ok ? KIND_IDENT : KIND_TERM;
    end
    return KIND_TERM;
  endfunction

  // append one expected beat and log its kind for the directed checks
  function automatic void queue_token(token_t t);
    token_q = {token_q, t};
    kind_log = {kind_log, t.kind};
  endfunction

  function automatic void push_token(logic [5:0] kind, longint start, longint len);
    token_t t;
    if (kind == KIND_TERM) return;
    t.kind = kind;
    t.start = start[15:0];
    t.len = len[15:0];
    t.line = row_no[15:0];
    t.col = 16'(start - row_start + 1);
    t.last = 1'b0;
    queue_token(t);
  endfunction

  function automatic void clear_state();
    pos = 0; tok_begin = 0; row_no = 1; row_start = 0; pend_len = 0;
    quoted = 0; held_ok = 0; merged = 0; num_ok = 1; point_ok = 0; ident_ok = 1;
    held = 0; last_ch = 0;
    foreach (pfx[i]) pfx[i] = 0;
  endfunction

  function automatic void flush_token();
    if (pend_len > 0) push_token(token_class(), tok_begin, pend_len);
    pend_len = 0;
  endfunction

  function automatic void drop_held();
    if (op_slot(held) >= 0) push_token(KIND_SINGLE + 6'(op_slot(held)), tok_begin, 1);
    held_ok = 0;
  endfunction

  // advance the mirror by one accepted byte and queue the tokens it closes
  function automatic void tokenize_byte(byte unsigned c, bit eot);
    token_t t;
    logic [5:0] pk;
    bit blank;
    merged = 0;
    if (held_ok) begin
      pk = op_slot(c) >= 0 ? pair_of(held, c) : KIND_TERM;
      if (pk != KIND_TERM) begin
        push_token(pk, tok_begin, 2);
        held_ok = 0;
        merged = 1;
      end else begin
        drop_held();
      end
    end
    if (!merged) begin
      blank = c == CH_SPACE || c == CH_TAB || c == CH_NL;
      if ((blank || op_slot(c) >= 0) && !quoted) begin
        flush_token();
        if (c == CH_NL) begin
          row_no = sat_inc(row_no);
          row_start = sat_inc(pos);
        end
        if (op_slot(c) >= 0) begin
          held = c; held_ok = 1; tok_begin = pos;
        end
      end else begin
        if (c == CH_DQUOT) quoted = ~quoted;
        if (pend_len == 0) begin
          tok_begin = pos;
          foreach (pfx[i]) pfx[i] = 0;
          num_ok = 1; point_ok = 0; ident_ok = 1;
        end else begin
          if (!digit(c)) begin
            if (c == CH_POINT && !point_ok) point_ok = 1;
            else num_ok = 0;
          end
          if (!digit(c) && !letter(c)) ident_ok = 0;
        end
        if (pend_len < 6) pfx[pend_len] = c;
        last_ch = c;
        pend_len = sat_inc(pend_len);
      end
    end
    pos = sat_inc(pos);
    if (eot) begin
      if (held_ok) drop_held();
      flush_token();
      t = '{KIND_TERM, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
      queue_token(t);
      clear_state();
    end
  endfunction

  // compare each accepted beat with the oldest expected token
  always @(posedge clk) begin
    token_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("unexpected beat kind=%0d", out_token_kind);
        fail_count++;
      end else begin
        t = token_q.pop_front();
        if (out_token_kind !== t.kind) begin
          $error("token_kind expected %0d got %0d", t.kind, out_token_kind); fail_count++;
        end
        if (out_token_start !== t.start) begin
          $error("token_start expected %0d got %0d", t.start, out_token_start); fail_count++;
        end
        if (out_token_length !== t.len) begin
          $error("token_length expected %0d got %0d", t.len, out_token_length); fail_count++;
        end
        if (out_line_number !== t.line) begin
          $error("line_number expected %0d got %0d", t.line, out_line_number); fail_count++;
        end
        if (out_column_number !== t.col) begin
          $error("column_number expected %0d got %0d", t.col, out_column_number); fail_count++;
        end
        if (out_last_result !== t.last) begin
          $error("last_result expected %0d got %0d", t.last, out_last_result); fail_count++;
        end
      end
    end
  end

  // offer one byte from the falling edge and hold it until accepted
  task automatic send_byte(byte unsigned c, bit eot);
    if (send_idle) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_source_char = c;
    in_end_of_text = eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(c, eot);
    @(negedge clk);
  endtask

  task automatic send_buf();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
    in_valid = 1'b0;
  endtask

  task automatic add_byte(byte unsigned b);
    text_buf = {text_buf, b};
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // build a random text of plausible tokens with some noise and broken words
  task automatic build_text(int words);
    string kws[12] = '{"byte", "short", "int", "long", "char", "float", "double",
                       "string", "if", "else", "while", "return"};
    int n;
    for (int w = 0; w < words; w++) begin
      case ($urandom_range(10))
        0: add_str(kws[$urandom_range(11)]);
        1: begin
          n = $urandom_range(1, 7);
          add_byte(8'("a" + $urandom_range(25)));
          for (int i = 1; i < n; i++)
            add_byte($urandom_range(1) ? 8'("A" + $urandom_range(25))
                                       : 8'("0" + $urandom_range(9)));
        end
        2: repeat ($urandom_range(1, 5)) add_byte(8'("0" + $urandom_range(9)));
        3: begin
          add_str("3");
          add_byte(CH_POINT);
          repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(9)));
          if ($urandom_range(3) == 0) add_byte(CH_POINT);
        end
        4: begin
          add_byte(CH_DQUOT);
          repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(1, 255)));
          if ($urandom_range(4) != 0) add_byte(CH_DQUOT);
        end
        5: begin
          add_byte(CH_SQUOT);
          add_byte(8'($urandom_range(33, 126)));
          add_byte(CH_SQUOT);
        end
        6, 7: add_byte(OPS[$urandom_range(19)]);
        8: begin
          n = $urandom_range(7);
          add_byte(PAIR_A[n]);
          add_byte(PAIR_B[n]);
        end
        9: add_byte(8'($urandom_range(0, 255)));
        default: begin
          add_byte(8'("a" + $urandom_range(25)));
          add_byte(8'($urandom_range(128, 255)));
        end
      endcase
      case ($urandom_range(5))
        0: add_byte(CH_TAB);
        1: add_byte(CH_NL);
        2, 3: add_byte(CH_SPACE);
        default: ;
      endcase
    end
  endtask

  task automatic drain();
    while (token_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    text_row_t rows[21];
    int base;
    rows = '{
      '{"a==b", KIND_IDENT}, '{"!=", KIND_NE}, '{">=", KIND_GE}, '{"<=", KIND_LE},
      '{"<<", KIND_SHL}, '{">>", KIND_SHR}, '{"&&", KIND_LAND}, '{"||", KIND_LOR},
      '{";,{}[]()", KIND_SINGLE}, '{"=+-*/&|^~><!", KIND_SINGLE + 6'd8},
      '{"'c'", KIND_CHAR}, '{"\"a b\n;\"", KIND_STR}, '{"123", KIND_INT},
      '{"1.5", KIND_FLOAT}, '{"1.2.3", KIND_TERM},
      '{"byte short int long char float double string if else while return", KIND_KW},
      '{"ab_c", KIND_TERM}, '{"\"abc", KIND_TERM}, '{"\t\n x", KIND_IDENT},
      '{" ", KIND_TERM}, '{"q", KIND_IDENT}};
    clear_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed texts, each closed by the end flag on its last byte
    foreach (rows[r]) begin
      base = kind_log.size();
      add_str(rows[r].text);
      send_buf();
      if (kind_log[base] !== 6'(rows[r].first_kind)) begin
        $error("token_kind expected %0d got %0d", rows[r].first_kind, kind_log[base]);
        fail_count++;
      end
    end
    // zero and high bytes inside words
    text_buf = '{8'h00, CH_SPACE, 8'h80, 8'hFF, "a", 8'h7F};
    send_buf();
    drain();

    // random texts across idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = ph == 1 || ph == 3;
      recv_idle = ph == 2 || ph == 3;
      idle_pct = (ph == 3) ? 17 : 68;
      if (ph == 1) hold_cycles = 300;
      for (int t = 0; t < 3; t++) begin
        build_text($urandom_range(6, 14));
        send_buf();
      end
      // after the first phase, pause until every expected token has come
      if (ph == 0) drain();
    end

    send_idle = 1'b0;
    recv_idle = 1'b0;
    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
